[rtl/bfdh_pkg.sv]
// Shared types, constants and hash helpers for the double-hashing Bloom filter.
// No dependencies; the other files that use it refer to this package by scoped name.
`default_nettype none
package bfdh_pkg;

    localparam int unsigned MAX_BITS    = 65536;
    localparam int unsigned MAX_PROBES  = 16;
    localparam int unsigned STORE_WORDS = (MAX_BITS + 63) / 64;
    localparam int unsigned WORD_AW     = $clog2(STORE_WORDS);
    localparam int unsigned IDX_W       = $clog2(MAX_BITS);
    localparam int unsigned M_W         = 17;
    localparam int unsigned K_W         = 5;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

    localparam logic [M_W-1:0] FILTER_BITS_RST = 17'd65536;
    localparam logic [K_W-1:0] PROBE_COUNT_RST = 5'd7;

    localparam logic [63:0] HASH_BASIS = 64'h84222325cbf849c3;
    localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_RD,
        ST_CHK,
        ST_DONE
    } back_state_t;

    // one closed key waiting for the back end
    typedef struct packed {
        logic [63:0] hash;
        logic        add;
    } key_entry_t;

    // clamped filter geometry
    typedef struct packed {
        logic [M_W-1:0] m;
        logic [K_W-1:0] k;
    } geom_t;

    // FNV-1a fold; prime 0x100000001b3 = 2^40 + 0x1b3, done as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

    function automatic logic [M_W-1:0] clamp_m(input logic [M_W-1:0] v);
        if (v < M_W'(64))
            return M_W'(64);
        else if (v > M_W'(MAX_BITS))
            return M_W'(MAX_BITS);
        return v;
    endfunction

    function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] v);
        if (v == '0)
            return K_W'(1);
        else if (v > K_W'(MAX_PROBES))
            return K_W'(MAX_PROBES);
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/bfdh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bfdh_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/bfdh_queue.sv]
// Two-entry queue of closed keys between the hashing front and the probe back end.
// Uses bfdh_pkg::key_entry_t.
`default_nettype none
module bfdh_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bfdh_pkg::key_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output bfdh_pkg::key_entry_t     head
);

    bfdh_pkg::key_entry_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bfdh_front.sv]
// Front end: takes key bytes, folds them into the running hash, queues closed keys.
// Uses bfdh_pkg (fnv_step, HASH_BASIS, key_entry_t).
`default_nettype none
module bfdh_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                mode,
    input  wire logic [7:0]          key_byte,
    input  wire logic                byte_present,
    input  wire logic                last,
    input  wire logic                enable,
    input  wire logic                q_full,
    output logic                     q_push,
    output bfdh_pkg::key_entry_t     q_data
);

    logic [63:0] hash_reg, hash_next;
    logic [63:0] folded;
    logic        take;

    assign in_ready = enable && !q_full;
    assign take     = in_valid && in_ready;
    assign folded   = byte_present ? bfdh_pkg::fnv_step(hash_reg, key_byte) : hash_reg;

    assign q_push      = take && last;
    assign q_data.hash = folded;
    assign q_data.add  = mode;

    always_comb
    begin
        hash_next = hash_reg;
        if (take)
            hash_next = last ? bfdh_pkg::HASH_BASIS : folded;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= bfdh_pkg::HASH_BASIS;
        else
            hash_reg <= hash_next;
    end

endmodule
`default_nettype wire

[rtl/bfdh_back.sv]
// Back end: splitmix64 on a shared 32x32 multiplier, serial mod m, probe sequencing
// on the bit store and the result register. Uses bfdh_pkg and bfdh_ram.
`default_nettype none
module bfdh_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bfdh_pkg::geom_t      geom,
    input  wire logic                 q_empty,
    input  wire bfdh_pkg::key_entry_t q_head,
    output logic                      q_pop,
    output logic                      ready_en,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit,
    output logic [31:0]               added_count,
    output logic                      was_add
);

    localparam int unsigned AW = bfdh_pkg::WORD_AW;
    localparam int unsigned IW = bfdh_pkg::IDX_W;
    localparam int unsigned MW = bfdh_pkg::M_W;
    localparam int unsigned KW = bfdh_pkg::K_W;

    bfdh_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_done_reg, clr_done_next;
    logic [63:0]   v_reg, v_next;
    logic [63:0]   acc_reg, acc_next;
    logic [1:0]    step_reg, step_next;
    logic          phase_reg, phase_next;
    logic          add_reg, add_next;
    logic [31:0]   h1_reg, h1_next;
    logic [31:0]   h2_reg, h2_next;
    logic [IW-1:0] rem1_reg, rem1_next;
    logic [IW-1:0] rem2_reg, rem2_next;
    logic [4:0]    bitcnt_reg, bitcnt_next;
    logic [KW-1:0] probe_reg, probe_next;
    logic          all_set_reg, all_set_next;
    logic          out_valid_reg, out_valid_next;
    logic          hit_reg, hit_next;
    logic [31:0]   count_reg, count_next;
    logic          was_add_reg, was_add_next;

    logic [31:0]   mul_a, mul_c;
    logic [63:0]   prod, full;
    logic [63:0]   mixed_in;
    logic [MW-1:0] r1_try, r2_try, sum;
    logic          out_free;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata, ram_rdata, mask;

    bfdh_ram #(.WIDTH(64), .DEPTH(bfdh_pkg::STORE_WORDS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rem1_reg[IW-1:6]),
        .rdata (ram_rdata)
    );

    // rem1 doubles as the current probe index, rem2 as the step h2 mod m
    assign mask     = 64'd1 << rem1_reg[5:0];
    assign out_free = !out_valid_reg || out_ready;
    assign mixed_in = q_head.hash ^ (q_head.hash >> 30);

    assign mul_a = (step_reg == 2'd1) ? v_reg[63:32] : v_reg[31:0];
    assign mul_c = (step_reg == 2'd2) ? (phase_reg ? bfdh_pkg::MIX_C2[63:32]
                                                   : bfdh_pkg::MIX_C1[63:32])
                                      : (phase_reg ? bfdh_pkg::MIX_C2[31:0]
                                                   : bfdh_pkg::MIX_C1[31:0]);
    assign prod  = mul_a * mul_c;
    assign full  = acc_reg + ((step_reg == 2'd0) ? prod : {prod[31:0], 32'd0});

    assign r1_try = {rem1_reg, h1_reg[31]};
    assign r2_try = {rem2_reg, h2_reg[31]};
    assign sum    = MW'(rem1_reg) + MW'(rem2_reg);

    assign ram_we    = (state_reg == bfdh_pkg::ST_CLEAR)
                    || (state_reg == bfdh_pkg::ST_CHK && add_reg);
    assign ram_waddr = (state_reg == bfdh_pkg::ST_CLEAR) ? clr_addr_reg : rem1_reg[IW-1:6];
    assign ram_wdata = (state_reg == bfdh_pkg::ST_CLEAR) ? 64'd0 : (ram_rdata | mask);

    assign ready_en    = clr_done_reg;
    assign q_pop       = (state_reg == bfdh_pkg::ST_IDLE) && !q_empty;
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign added_count = count_reg;
    assign was_add     = was_add_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfdh_pkg::ST_CLEAR:
                if (clr_addr_reg == '1)
                    state_next = bfdh_pkg::ST_IDLE;
            bfdh_pkg::ST_IDLE:
                if (!q_empty)
                    state_next = bfdh_pkg::ST_MIX;
            bfdh_pkg::ST_MIX:
                if (step_reg == 2'd2 && phase_reg)
                    state_next = bfdh_pkg::ST_DIV;
            bfdh_pkg::ST_DIV:
                if (bitcnt_reg == '1)
                    state_next = bfdh_pkg::ST_RD;
            bfdh_pkg::ST_RD:
                state_next = bfdh_pkg::ST_CHK;
            bfdh_pkg::ST_CHK:
                if (probe_reg + KW'(1) == geom.k)
                    state_next = bfdh_pkg::ST_DONE;
                else
                    state_next = bfdh_pkg::ST_RD;
            bfdh_pkg::ST_DONE:
                if (out_free)
                    state_next = bfdh_pkg::ST_IDLE;
            default:
                state_next = bfdh_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        clr_done_next  = clr_done_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        add_next       = add_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        rem1_next      = rem1_reg;
        rem2_next      = rem2_reg;
        bitcnt_next    = bitcnt_reg;
        probe_next     = probe_reg;
        all_set_next   = all_set_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        was_add_next   = was_add_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            bfdh_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                    clr_done_next = 1'b1;
            end
            bfdh_pkg::ST_IDLE:
            begin
                v_next       = mixed_in;
                add_next     = q_head.add;
                acc_next     = '0;
                step_next    = 2'd0;
                phase_next   = 1'b0;
                all_set_next = 1'b1;
            end
            bfdh_pkg::ST_MIX:
            begin
                acc_next  = full;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    acc_next   = '0;
                    step_next  = 2'd0;
                    phase_next = 1'b1;
                    v_next     = full ^ (full >> 27);
                    if (phase_reg)
                    begin
                        h1_next     = full[63:32] ^ {31'd0, full[63]};
                        h2_next     = full[31:0] ^ full[62:31];
                        rem1_next   = '0;
                        rem2_next   = '0;
                        bitcnt_next = '0;
                    end
                end
            end
            bfdh_pkg::ST_DIV:
            begin
                // one quotient bit per cycle for both halves
                rem1_next   = (r1_try >= geom.m) ? IW'(r1_try - geom.m) : IW'(r1_try);
                rem2_next   = (r2_try >= geom.m) ? IW'(r2_try - geom.m) : IW'(r2_try);
                h1_next     = {h1_reg[30:0], 1'b0};
                h2_next     = {h2_reg[30:0], 1'b0};
                bitcnt_next = bitcnt_reg + 5'd1;
                probe_next  = '0;
            end
            bfdh_pkg::ST_RD:
            begin
            end
            bfdh_pkg::ST_CHK:
            begin
                if (!add_reg && (ram_rdata & mask) == 64'd0)
                    all_set_next = 1'b0;
                rem1_next  = (sum >= geom.m) ? IW'(sum - geom.m) : IW'(sum);
                probe_next = probe_reg + KW'(1);
            end
            bfdh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = all_set_reg && !add_reg;
                    was_add_next   = add_reg;
                    if (add_reg && count_reg != bfdh_pkg::COUNT_MAX)
                        count_next = count_reg + 32'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        step_reg    <= step_next;
        phase_reg   <= phase_next;
        add_reg     <= add_next;
        h1_reg      <= h1_next;
        h2_reg      <= h2_next;
        rem1_reg    <= rem1_next;
        rem2_reg    <= rem2_next;
        bitcnt_reg  <= bitcnt_next;
        probe_reg   <= probe_next;
        all_set_reg <= all_set_next;
        hit_reg     <= hit_next;
        was_add_reg <= was_add_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfdh_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_done_reg  <= clr_done_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/bloom_filter_double_hash_core.sv]
// Top level of the double-hashing Bloom filter: configuration registers and the
// wiring of front end, key queue and back end. Uses bfdh_pkg and the bfdh_* modules.
//
// Usage
//   Input channel (in_valid/in_ready): one key byte per request, with byte_present
//   and last. Bytes are folded into the hash as they are taken, so a key streams
//   in at one request per cycle while in_ready is high. The request with last set
//   closes the key and carries mode (1 add, 0 query); closed keys wait in a two-entry
//   queue. Output channel (out_valid/out_ready): one result request per closed key,
//   giving hit, was_add and the saturating added_count.
//   Processing: a closed key goes through splitmix64 on one shared multiplier
//   (three 32x32 partial products per 64-bit multiply), then bit-serial mod m
//   for h1 and h2 together, then per probe a read of the word and a check or set
//   of it; the queue pop comes first and the result load last. The back end works
//   on one key at a time and takes another only after the last result is loaded;
//   the serial modulo and the RAM read-modify-write per probe set the time per key.
//   Reset: the bit store is cleared by a pass over its 1024 words, one word per cycle;
//   in_ready stays low until it is done. Configuration writes are taken throughout.
//   Stall: a held result sits in the output register; the back end waits on it,
//   while the front end keeps accepting bytes until the key queue fills.
//   Config: cfg_we/cfg_index/cfg_data; index 0 filter_bits, 1 probe_count.
`default_nettype none
module bloom_filter_double_hash_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               mode,
    input  wire logic [7:0]                         key_byte,
    input  wire logic                               byte_present,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    hit,
    output logic [31:0]                             added_count,
    output logic                                    was_add,
    input  wire logic                               cfg_we,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bfdh_pkg::M_W-1:0] filter_bits_reg, filter_bits_next;
    logic [bfdh_pkg::K_W-1:0] probe_count_reg, probe_count_next;

    bfdh_pkg::geom_t      geom;
    bfdh_pkg::key_entry_t q_data, q_head;
    logic                 q_push, q_pop, q_full, q_empty, ready_en;

    // raw values are kept; clamping happens on the way to the back end
    always_comb
    begin
        filter_bits_next = filter_bits_reg;
        probe_count_next = probe_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bfdh_pkg::REG_FILTER_BITS: filter_bits_next = cfg_data;
                bfdh_pkg::REG_PROBE_COUNT: probe_count_next = cfg_data[bfdh_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= bfdh_pkg::FILTER_BITS_RST;
            probe_count_reg <= bfdh_pkg::PROBE_COUNT_RST;
        end
        else
        begin
            filter_bits_reg <= filter_bits_next;
            probe_count_reg <= probe_count_next;
        end
    end

    assign geom.m = bfdh_pkg::clamp_m(filter_bits_reg);
    assign geom.k = bfdh_pkg::clamp_k(probe_count_reg);

    bfdh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .last         (last),
        .enable       (ready_en),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    bfdh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    bfdh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ready_en    (ready_en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .added_count (added_count),
        .was_add     (was_add)
    );

endmodule
`default_nettype wire

[rtl/bfdh_checker.sv]
// Port-level checks for bloom_filter_double_hash_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module bfdh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [31:0] added_count,
    input wire logic        was_add
);

    // store clear still running straight after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !in_ready)
        else $error("input taken during store clear");

    assert property (@(posedge clk) disable iff (!rst_n) out_valid && hit |-> !was_add)
        else $error("add reported a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_add |-> added_count != 32'd0)
        else $error("add result with zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(added_count) && $stable(hit))
        else $error("stalled result changed");

endmodule

bind bloom_filter_double_hash_core bfdh_checker u_bfdh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .added_count (added_count),
    .was_add     (was_add)
);
`default_nettype wire
